/* hw/rtl/rvpf_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// RGB to visual pixel formatter - shared definitions
// Codes, register indexes, pipeline constants and the divider step.
// -----------------------------------------------------------------------------
package rvpf_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CHAN_W / BITS_PER_STAGE;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [1:0] MODE_TRUE    = 2'd0;
    localparam logic [1:0] MODE_PALETTE = 2'd1;
    localparam logic [1:0] MODE_GRAY    = 2'd2;

    localparam logic [2:0] REG_VISUAL_MODE   = 3'd0;
    localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd1;
    localparam logic [2:0] REG_MSB_FIRST     = 3'd2;
    localparam logic [2:0] REG_CHANNEL_SHIFT = 3'd3;
    localparam logic [2:0] REG_LEVELS        = 3'd4;
    localparam logic [2:0] REG_RED_DIV       = 3'd5;
    localparam logic [2:0] REG_GREEN_DIV     = 3'd6;
    localparam logic [2:0] REG_BLUE_DIV      = 3'd7;

    // luminance weights, sum divided by 100 via reciprocal
    localparam logic [14:0] GRAY_WR    = 15'd30;
    localparam logic [14:0] GRAY_WG    = 15'd59;
    localparam logic [14:0] GRAY_WB    = 15'd11;
    localparam logic [15:0] GRAY_RECIP = 16'd41944;
    localparam int          GRAY_SHIFT = 22;

    typedef struct packed {
        logic       func;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
    } t_tag;

    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [CHAN_W-1:0] x;
        logic [CHAN_W-1:0] q;
    } t_lane;

    // restoring division, BITS_PER_STAGE quotient bits
    function automatic t_lane div_step(t_lane a, logic [CHAN_W-1:0] d);
        t_lane           o;
        logic [CHAN_W:0] t;
        o = a;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            t   = {o.rem, o.x[CHAN_W-1]};
            o.x = {o.x[CHAN_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                o.rem = CHAN_W'(t - {1'b0, d});
                o.q   = {o.q[CHAN_W-2:0], 1'b1};
            end else begin
                o.rem = t[CHAN_W-1:0];
                o.q   = {o.q[CHAN_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rgb_to_visual_pixel_formatter.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// RGB to visual pixel formatter - top level
// Quantises an RGB pixel and emits true-colour bytes or one palette byte.
// -----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   40+1   tdata: red, green, blue, entry_index, entry_value; tuser: func
// m_axis    out  8+1    tdata: data_byte; tlast: last_byte
// cfg       in   3+8    register index, write data
//
// A transaction can enter every cycle unless the pipeline holds; it passes the
// divider stages, c1, c2, c3, m and the serialiser. One byte per cycle leaves while
// m_axis_tready is high; a true-colour pixel gives pixel_format+1, palette/gray one.
// The whole pipeline holds while the output byte register waits.
// Synchronous active-low reset clears valids and config registers; palette is unset.
// -----------------------------------------------------------------------------
module rgb_to_visual_pixel_formatter import rvpf_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // red, green, blue, entry_index, entry_value
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // data_byte
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    // configuration
    logic [1:0] r_mode;
    logic [1:0] r_fmt;
    logic       r_msb;
    logic [4:0] r_shift;
    logic [4:0] r_lv;
    logic [7:0] r_div_r, r_div_g, r_div_b;
    logic [9:0] r_lv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TRUE;
            r_fmt   <= 2'd3;
            r_msb   <= 1'b0;
            r_shift <= 5'd8;
            r_lv    <= 5'd6;
            r_div_r <= 8'd1;
            r_div_g <= 8'd1;
            r_div_b <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_VISUAL_MODE:   r_mode  <= i_cfg_data[1:0];
                REG_PIXEL_FORMAT:  r_fmt   <= i_cfg_data[1:0];
                REG_MSB_FIRST:     r_msb   <= i_cfg_data[0];
                REG_CHANNEL_SHIFT: r_shift <= i_cfg_data[4:0];
                REG_LEVELS:        r_lv    <= i_cfg_data[4:0];
                REG_RED_DIV:       r_div_r <= i_cfg_data;
                REG_GREEN_DIV:     r_div_g <= i_cfg_data;
                REG_BLUE_DIV:      r_div_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv2 <= 10'(r_lv) * 10'(r_lv);
    end

    // pipeline control
    logic adv;
    logic r_s_vld;
    logic s_last;

    assign adv           = !r_s_vld || (m_axis_tready && s_last);
    assign s_axis_tready = adv;

    // quantiser
    t_tag                            in_tag;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] in_chan;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] in_div;
    logic                            q_vld;
    t_tag                            q_tag;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] q_quo;

    assign in_tag.func        = s_axis_tuser;
    assign in_tag.entry_index = s_axis_tdata[31:24];
    assign in_tag.entry_value = s_axis_tdata[39:32];
    assign in_chan[0]         = s_axis_tdata[7:0];
    assign in_chan[1]         = s_axis_tdata[15:8];
    assign in_chan[2]         = s_axis_tdata[23:16];
    assign in_div[0]          = (r_div_r == 8'd0) ? 8'd1 : r_div_r;
    assign in_div[1]          = (r_div_g == 8'd0) ? 8'd1 : r_div_g;
    assign in_div[2]          = (r_div_b == 8'd0) ? 8'd1 : r_div_b;

    rvpf_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (s_axis_tvalid),
        .i_tag   (in_tag),
        .i_chan  (in_chan),
        .i_div   (in_div),
        .o_vld   (q_vld),
        .o_tag   (q_tag),
        .o_quo   (q_quo)
    );

    // products and packed word
    logic        r_c1_vld, r_c2_vld, r_c3_vld, r_m_vld;
    t_tag        r_c1_tag, r_c2_tag, r_c3_tag;
    logic [31:0] r_c1_word, r_c2_word, r_c3_word, r_m_word;
    logic [17:0] r_c1_pr;
    logic [12:0] r_c1_pg;
    logic [7:0]  r_c1_b;
    logic [14:0] r_c1_gr, r_c1_gg, r_c1_gb;
    logic [17:0] r_c2_pal, r_c3_pal;
    logic [14:0] r_c2_gray;
    logic [7:0]  r_c3_gray;
    logic        r_m_func;
    logic [7:0]  r_rd;
    logic [63:0] word64;
    logic [30:0] gray_prod;

    assign word64 = (64'(q_quo[0]) << {r_shift, 1'b0})
                  | (64'(q_quo[1]) << r_shift)
                  | 64'(q_quo[2]);
    assign gray_prod = 31'(r_c2_gray) * 31'(GRAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_c3_vld <= 1'b0;
            r_m_vld  <= 1'b0;
        end else if (adv) begin
            r_c1_vld <= q_vld;
            r_c2_vld <= r_c1_vld;
            r_c3_vld <= r_c2_vld;
            r_m_vld  <= r_c3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1_tag  <= q_tag;
            r_c1_word <= word64[31:0];
            r_c1_pr   <= 18'(q_quo[0]) * 18'(r_lv2);
            r_c1_pg   <= 13'(q_quo[1]) * 13'(r_lv);
            r_c1_b    <= q_quo[2];
            r_c1_gr   <= 15'(q_quo[0]) * GRAY_WR;
            r_c1_gg   <= 15'(q_quo[1]) * GRAY_WG;
            r_c1_gb   <= 15'(q_quo[2]) * GRAY_WB;

            r_c2_tag  <= r_c1_tag;
            r_c2_word <= r_c1_word;
            r_c2_pal  <= r_c1_pr + 18'(r_c1_pg) + 18'(r_c1_b);
            r_c2_gray <= r_c1_gr + r_c1_gg + r_c1_gb;

            r_c3_tag  <= r_c2_tag;
            r_c3_word <= r_c2_word;
            r_c3_pal  <= r_c2_pal;
            r_c3_gray <= gray_prod[GRAY_SHIFT +: 8];

            r_m_func  <= r_c3_tag.func;
            r_m_word  <= r_c3_word;
        end
    end

    // palette store
    logic [7:0]       r_pal [PALETTE_DEPTH];
    logic [17:0]      idx_full;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;

    assign idx_full = (r_mode == MODE_GRAY) ? 18'(r_c3_gray) : r_c3_pal;
    assign rd_addr  = (idx_full >= 18'(PALETTE_DEPTH)) ? IDX_W'(PALETTE_DEPTH - 1)
                                                       : idx_full[IDX_W-1:0];
    assign wr_en    = adv && r_c3_vld && (r_c3_tag.func == FUNC_WRITE)
                    && (9'(r_c3_tag.entry_index) < 9'(PALETTE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pal[r_c3_tag.entry_index[IDX_W-1:0]] <= r_c3_tag.entry_value;
        end
        if (adv) begin
            r_rd <= r_pal[rd_addr];
        end
    end

    // output byte serialiser
    logic        need;
    logic [31:0] r_s_word;
    logic [1:0]  r_s_n1;
    logic [1:0]  r_s_k;
    logic        r_s_msb;
    logic [1:0]  pos;

    assign need = r_m_vld && (r_m_func == FUNC_PIXEL)
               && ((r_mode == MODE_TRUE) || (r_mode == MODE_PALETTE) || (r_mode == MODE_GRAY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_s_k   <= 2'd0;
        end else if (adv) begin
            r_s_vld <= need;
            r_s_k   <= 2'd0;
        end else if (m_axis_tready) begin
            r_s_k   <= r_s_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s_msb <= r_msb;
            if (r_mode == MODE_TRUE) begin
                r_s_word <= r_m_word;
                r_s_n1   <= r_fmt;
            end else begin
                r_s_word <= {24'd0, r_rd};
                r_s_n1   <= 2'd0;
            end
        end
    end

    assign pos           = r_s_msb ? 2'(r_s_n1 - r_s_k) : r_s_k;
    assign s_last        = (r_s_k == r_s_n1);
    assign m_axis_tvalid = r_s_vld;
    assign m_axis_tdata  = r_s_word[{pos, 3'b000} +: 8];
    assign m_axis_tlast  = s_last;

endmodule
`default_nettype wire

/* hw/rtl/rvpf_qdiv.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// RGB to visual pixel formatter - channel quantiser
// Pipelined restoring divider, three channels side by side, tag carried along.
// -----------------------------------------------------------------------------
module rvpf_qdiv import rvpf_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_vld,
    input  t_tag                             i_tag,
    input  logic [NUM_CHAN-1:0][CHAN_W-1:0]  i_chan,
    input  logic [NUM_CHAN-1:0][CHAN_W-1:0]  i_div,
    output logic                             o_vld,
    output t_tag                             o_tag,
    output logic [NUM_CHAN-1:0][CHAN_W-1:0]  o_quo
);

    logic [DIV_STAGES-1:0] r_vld;
    t_tag                  r_tag  [DIV_STAGES];
    t_lane                 r_lane [DIV_STAGES][NUM_CHAN];
    t_lane                 n_lane [DIV_STAGES][NUM_CHAN];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
            if (s == 0) begin : g_first
                always_comb begin
                    n_lane[s][c] = div_step('{rem: '0, x: i_chan[c], q: '0}, i_div[c]);
                end
            end else begin : g_next
                always_comb begin
                    n_lane[s][c] = div_step(r_lane[s-1][c], i_div[c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            r_lane <= n_lane;
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_tag = r_tag[DIV_STAGES-1];

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            o_quo[c] = r_lane[DIV_STAGES-1][c].q;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rvpf_checker.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// RGB to visual pixel formatter - port checker
// Watches the top-level ports; bound to the top level.
// -----------------------------------------------------------------------------
module rvpf_checker import rvpf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_addr,
    input logic [7:0]  i_cfg_data
);

    logic [1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TRUE;
        end else if (i_cfg_we && (i_cfg_addr == REG_VISUAL_MODE)) begin
            r_mode <= i_cfg_data[1:0];
        end
    end

    // held transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // input side never blocks while the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_mode != MODE_TRUE) |-> m_axis_tlast)
        else $error("palette or gray pixel sent more than one byte");

endmodule

bind rgb_to_visual_pixel_formatter rvpf_checker u_rvpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_addr    (i_cfg_addr),
    .i_cfg_data    (i_cfg_data)
);
`default_nettype wire

/* tb/tb_rgb_to_visual_pixel_formatter.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// RGB to visual pixel formatter - testbench
// Drives pixel and palette-write transactions under several register settings
// (true colour, palette cube, grey, unused mode) and compares every output
// byte with a byte queue built by an in-bench model of the formatter.
// -----------------------------------------------------------------------------
module tb_rgb_to_visual_pixel_formatter;
    import rvpf_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 40;
    localparam int NUM_PHASES   = 12;

    typedef struct packed {
        logic       func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
    } t_pixel_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_out_byte;

    class pixel_byte_board;
        logic [1:0] mode;
        logic [1:0] fmt;
        logic       msb;
        logic [4:0] shift;
        logic [4:0] levels;
        logic [7:0] div_r;
        logic [7:0] div_g;
        logic [7:0] div_b;
        logic [7:0] palette [PALETTE_DEPTH_DEF];
        bit         written [PALETTE_DEPTH_DEF];
        t_out_byte  pending_bytes [$];
        int         errors;

        function new();
            mode   = MODE_TRUE;
            fmt    = 2'd3;
            msb    = 1'b0;
            shift  = 5'd8;
            levels = 5'd6;
            div_r  = 8'd1;
            div_g  = 8'd1;
            div_b  = 8'd1;
            errors = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [7:0] value);
            case (addr)
                REG_VISUAL_MODE:   mode   = value[1:0];
                REG_PIXEL_FORMAT:  fmt    = value[1:0];
                REG_MSB_FIRST:     msb    = value[0];
                REG_CHANNEL_SHIFT: shift  = value[4:0];
                REG_LEVELS:        levels = value[4:0];
                REG_RED_DIV:       div_r  = value;
                REG_GREEN_DIV:     div_g  = value;
                REG_BLUE_DIV:      div_b  = value;
                default: ;
            endcase
        endfunction

        // zero divisor behaves as one
        function logic [7:0] quantise(logic [7:0] v, logic [7:0] d);
            return (d == 8'd0) ? v : v / d;
        endfunction

        function int unsigned lookup_index(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned qr, qg, qb, lv, idx;
            qr = quantise(r, div_r);
            qg = quantise(g, div_g);
            qb = quantise(b, div_b);
            lv = levels;
            if (mode == MODE_GRAY)
                idx = (qr * 30 + qg * 59 + qb * 11) / 100;
            else
                idx = qr * lv * lv + qg * lv + qb;
            if (idx >= PALETTE_DEPTH_DEF)
                idx = PALETTE_DEPTH_DEF - 1;
            return idx;
        endfunction

        function void take_item(t_pixel_item it);
            logic [63:0] word;
            logic [63:0] qr, qg, qb;
            int          n, pos;
            t_out_byte   ob;
            if (it.func == FUNC_WRITE) begin
                palette[it.entry_index] = it.entry_value;
                written[it.entry_index] = 1'b1;
                return;
            end
            case (mode)
                MODE_TRUE: begin
                    qr   = quantise(it.red, div_r);
                    qg   = quantise(it.green, div_g);
                    qb   = quantise(it.blue, div_b);
                    word = (((qr << shift) | qg) << shift) | qb;
                    n    = int'(fmt) + 1;
                    for (int k = 0; k < n; k++) begin
                        pos          = msb ? (n - 1 - k) : k;
                        ob.data_byte = word[8*pos +: 8];
                        ob.last_byte = (k == n - 1);
                        pending_bytes.push_back(ob);
                    end
                end
                MODE_PALETTE, MODE_GRAY: begin
                    ob.data_byte = palette[lookup_index(it.red, it.green, it.blue)];
                    ob.last_byte = 1'b1;
                    pending_bytes.push_back(ob);
                end
                default: ;
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic is_last);
            t_out_byte exp_b;
            if (pending_bytes.size() == 0) begin
                $error("unexpected byte: data_byte %02h last_byte %0b", data, is_last);
                errors++;
                return;
            end
            exp_b = pending_bytes.pop_front();
            if (data !== exp_b.data_byte) begin
                $error("data_byte: expected %02h, actual %02h", exp_b.data_byte, data);
                errors++;
            end
            if (is_last !== exp_b.last_byte) begin
                $error("last_byte: expected %0b, actual %0b", exp_b.last_byte, is_last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // red, green, blue, entry_index, entry_value
    logic        s_axis_tuser  = 1'b0; // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // data_byte
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_addr    = '0;
    logic [7:0]  i_cfg_data    = '0;

    pixel_byte_board board;
    int src_idle_pct  = 10;
    int sink_idle_pct = 82;
    int quiet_cycles  = 0;

    rgb_to_visual_pixel_formatter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // output side: check accepted bytes, random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_byte(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(t_pixel_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {it.entry_value, it.entry_index, it.blue, it.green, it.red};
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_item(it);
    endtask

    task automatic send_write(int idx, int val);
        t_pixel_item it;
        it.func        = FUNC_WRITE;
        it.red         = $urandom_range(255);
        it.green       = $urandom_range(255);
        it.blue        = $urandom_range(255);
        it.entry_index = idx[7:0];
        it.entry_value = val[7:0];
        send_item(it);
    endtask

    // palette and grey pixels only ever read entries already loaded
    task automatic send_pixel(int r, int g, int b);
        t_pixel_item it;
        int unsigned idx;
        if (board.mode == MODE_PALETTE || board.mode == MODE_GRAY) begin
            idx = board.lookup_index(r[7:0], g[7:0], b[7:0]);
            if (!board.written[idx])
                send_write(idx, $urandom_range(255));
        end
        it.func        = FUNC_PIXEL;
        it.red         = r[7:0];
        it.green       = g[7:0];
        it.blue        = b[7:0];
        it.entry_index = $urandom_range(255);
        it.entry_value = $urandom_range(255);
        send_item(it);
    endtask

    task automatic write_reg(logic [2:0] addr, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value[7:0];
        @(posedge i_clk);
        board.set_reg(addr, value[7:0]);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(int mode, int fmt, int msb, int shift, int lv,
                             int rdiv, int gdiv, int bdiv);
        wait_idle();
        write_reg(REG_VISUAL_MODE, mode);
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_MSB_FIRST, msb);
        write_reg(REG_CHANNEL_SHIFT, shift);
        write_reg(REG_LEVELS, lv);
        write_reg(REG_RED_DIV, rdiv);
        write_reg(REG_GREEN_DIV, gdiv);
        write_reg(REG_BLUE_DIV, bdiv);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_chan();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic random_items(int count);
        repeat (count) begin
            if ($urandom_range(99) < 15)
                send_write($urandom_range(255), $urandom_range(255));
            else
                send_pixel(pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    initial begin
        int shift_r;
        int lv_r;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: four bytes, LSB first, shift 8
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(8'h12, 8'h34, 8'h56);
        configure(MODE_TRUE, 3, 1, 8, 6, 1, 1, 1);
        send_pixel(8'h12, 8'h34, 8'h56);
        // shift beyond 16 truncates the packed word; zero divisors
        configure(MODE_TRUE, 0, 0, 31, 6, 0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(1, 2, 3);
        configure(MODE_TRUE, 1, 1, 0, 6, 255, 255, 255);
        send_pixel(255, 128, 254);
        send_write(0, 8'h00);
        send_write(255, 8'hFF);
        send_write(1, 8'hA5);
        configure(MODE_PALETTE, 3, 0, 8, 16, 1, 1, 1);
        send_pixel(0, 0, 0);
        send_pixel(0, 0, 1);
        send_pixel(255, 255, 255);   // saturates to the top entry
        configure(MODE_PALETTE, 3, 0, 8, 0, 1, 1, 1);
        send_pixel(200, 100, 50);
        configure(MODE_PALETTE, 3, 0, 8, 31, 1, 1, 1);
        send_pixel(255, 0, 0);
        configure(MODE_GRAY, 3, 0, 8, 6, 1, 1, 1);
        send_pixel(255, 255, 255);
        send_pixel(0, 0, 0);
        configure(3, 3, 0, 8, 6, 1, 1, 1);
        send_pixel(10, 20, 30);      // unused mode: no output

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 4) begin
                src_idle_pct  = 82;
                sink_idle_pct = 10;
            end else if (phase == 8) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (phase)
                0: configure(MODE_TRUE, 3, 0, 16, 2, 1, 1, 1);
                1: configure(MODE_TRUE, 0, 1, 1, 2, 1, 1, 1);
                2: configure(MODE_TRUE, 2, 1, 12, 6, 255, 3, 7);
                3: configure(MODE_PALETTE, 3, 0, 8, 2, 128, 128, 128);
                4: configure(MODE_PALETTE, 3, 0, 8, 16, 16, 16, 16);
                5: configure(MODE_GRAY, 3, 0, 8, 6, 1, 1, 1);
                default: begin
                    shift_r = ($urandom_range(3) == 0) ? $urandom_range(31)
                                                       : $urandom_range(1, 16);
                    lv_r    = ($urandom_range(3) == 0) ? $urandom_range(31)
                                                       : $urandom_range(2, 16);
                    configure(($urandom_range(9) == 0) ? 3 : $urandom_range(2),
                              $urandom_range(3), $urandom_range(1), shift_r, lv_r,
                              $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(255),
                              $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(255),
                              $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(255));
                end
            endcase
            random_items(PHASE_ITEMS);
        end

        wait_idle();
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
